// ===== rtl/core/peq3_pkg.sv =====
// ----------------------------------------------------------------------------
// peq3_pkg
// Shared types and constants of the three-band peaking equalizer: sample
// width, band count, register indexes and the payload structs of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

package peq3_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int NUM_BANDS    = 3;
    localparam int BAND_W       = $clog2(NUM_BANDS);

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND1    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND2    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND3    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_GAIN = 3'd3;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_in;
        logic                           block_end_in;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_out;
        logic                           block_end_out;
    } t_out_item;

endpackage

`default_nettype wire

// ===== rtl/core/parametric_eq_three_band_core.sv =====
// ----------------------------------------------------------------------------
// parametric_eq_three_band_core
// Three cascaded lattice peaking sections and an output gain, run by a small
// microprogram over one shared coefficient multiplier.
// ----------------------------------------------------------------------------
//
//  channel   direction   signals                                   payload
//  ------------------------------------------------------------------------------
//  in        in          i_in_valid / o_in_ready / i_in_data       t_in_item
//  out       out         o_out_valid / i_out_ready / o_out_data    t_out_item
//  cfg       in          i_cfg_valid / o_cfg_ready / i_cfg_index   i_cfg_data
//
//  one sample takes 30 microprogram steps after its transfer: 9 per band and
//  3 for the output gain, all through the single multiply / round pipeline.
//  a new sample can be taken from the cycle after the last step on, not before.
//  the result sits in an output register; the last step waits only if that
//  register is still full. config writes are always taken (o_cfg_ready high).
//  reset clears band state and coefficients and sets the output gain to unity.
//
`default_nettype none

module parametric_eq_three_band_core #(
    parameter int STATE_WIDTH    = 32,
    parameter int COEF_FRAC_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire peq3_pkg::t_in_item                  i_in_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output peq3_pkg::t_out_item                      o_out_data,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [peq3_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [3*(COEF_FRAC_BITS+4)-1:0]     i_cfg_data
);
    import peq3_pkg::*;

    localparam int SW     = STATE_WIDTH;
    localparam int F      = COEF_FRAC_BITS;
    localparam int CW     = F + 4;
    localparam int PW     = CW + SW;
    localparam int MAGW   = PW + 1 - F;
    localparam int AW     = SW + 2;
    localparam int STEP_W = 4;
    localparam int UC_LEN = 12;

    localparam logic [PW:0]    HALF     = (PW+1)'(1) << (F - 1);
    localparam logic [CW-1:0]  UNITY    = CW'(1) << F;
    localparam logic [SW-1:0]  ST_MAX   = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0]  ST_MIN   = {1'b1, {(SW-1){1'b0}}};
    localparam logic [SAMPLE_WIDTH-1:0] SMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    typedef enum logic [1:0] {CS_A, CS_B, CS_G, CS_OUT} t_csel;
    typedef enum logic [2:0] {VS_ZA, VS_ZB, VS_Y, VS_Y2, VS_T, VS_X} t_vsel;
    typedef enum logic [2:0] {
        ALU_NONE, ALU_Y, ALU_Y2, ALU_T, ALU_ZAB, ALU_X, ALU_OUT
    } t_alu;
    typedef enum logic [1:0] {SQ_NEXT, SQ_LOOP, SQ_DONE} t_seq;

    typedef struct packed {
        logic              mul_en;
        t_csel             csel;
        t_vsel             vsel;
        t_alu              alu;
        t_seq              seq;
        logic [STEP_W-1:0] target;
    } t_cw;

    localparam t_cw UC_NOP = '{mul_en: 1'b0, csel: CS_A, vsel: VS_X, alu: ALU_NONE,
                               seq: SQ_NEXT, target: '0};

    // product issued at step s is rounded at s+1 and consumed at s+2
    function automatic t_cw ucode(input logic [STEP_W-1:0] s);
        t_cw w;
        w = UC_NOP;
        case (s)
            4'd0: begin
                w.mul_en = 1'b1; w.csel = CS_B; w.vsel = VS_ZB;
            end
            4'd1: begin
                w.mul_en = 1'b1; w.csel = CS_A; w.vsel = VS_ZA;
            end
            4'd2: begin
                w.alu = ALU_Y;
            end
            4'd3: begin
                w.mul_en = 1'b1; w.csel = CS_B; w.vsel = VS_Y; w.alu = ALU_Y2;
            end
            4'd4: begin
                w = UC_NOP;
            end
            4'd5: begin
                w.mul_en = 1'b1; w.csel = CS_A; w.vsel = VS_Y2; w.alu = ALU_T;
            end
            4'd6: begin
                w.mul_en = 1'b1; w.csel = CS_G; w.vsel = VS_T;
            end
            4'd7: begin
                w.alu = ALU_ZAB;
            end
            4'd8: begin
                w.alu = ALU_X; w.seq = SQ_LOOP; w.target = 4'd0;
            end
            4'd9: begin
                w.mul_en = 1'b1; w.csel = CS_OUT; w.vsel = VS_X;
            end
            4'd10: begin
                w = UC_NOP;
            end
            4'd11: begin
                w.alu = ALU_OUT; w.seq = SQ_DONE;
            end
            default: begin
                w.seq = SQ_DONE;
            end
        endcase
        return w;
    endfunction

    function automatic logic [AW-1:0] sx(input logic [SW-1:0] v);
        return AW'(signed'(v));
    endfunction

    function automatic logic [SW-1:0] sat_st(input logic [AW-1:0] v);
        logic in_range;
        in_range = (&v[AW-1:SW-1]) || !(|v[AW-1:SW-1]);
        if (in_range) begin
            return v[SW-1:0];
        end
        return v[AW-1] ? ST_MIN : ST_MAX;
    endfunction

    // control and state
    logic                  r_busy;
    logic [STEP_W-1:0]     r_step;
    logic [BAND_W-1:0]     r_band;
    logic                  r_out_valid;
    logic [3*CW-1:0]       r_coefs [NUM_BANDS];
    logic [CW-1:0]         r_out_gain;
    logic [SW-1:0]         r_za [NUM_BANDS];
    logic [SW-1:0]         r_zb [NUM_BANDS];

    // datapath
    logic [SW-1:0]         r_x, r_y, r_y2, r_t, r_q;
    logic [PW-1:0]         r_p;
    logic                  r_p_neg;
    logic                  r_blk_end;
    t_out_item             r_out_data;

    t_cw                   cw;
    logic                  in_xfer;
    logic                  hold;
    logic [3*CW-1:0]       band_word;
    logic [CW-1:0]         mul_c, c_abs;
    logic [SW-1:0]         mul_v, v_abs;
    logic [PW:0]           mag_sum;
    logic [MAGW-1:0]       mag;
    logic [SW-1:0]         n_q;
    logic [SW-1:0]         za_cur, zb_cur;
    logic [SW-1:0]         alu_y, alu_y2, alu_t, alu_zb, alu_x;
    logic [SAMPLE_WIDTH-1:0] n_sample;
    logic                  q_fits;

    assign cw          = ucode(r_step);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign hold        = (cw.alu == ALU_OUT) && r_out_valid && !i_out_ready;
    assign o_in_ready  = !r_busy;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign band_word = r_coefs[r_band];
    assign za_cur    = r_za[r_band];
    assign zb_cur    = r_zb[r_band];

    always_comb begin
        case (cw.csel)
            CS_A:    mul_c = band_word[CW-1:0];
            CS_B:    mul_c = band_word[2*CW-1:CW];
            CS_G:    mul_c = band_word[3*CW-1:2*CW];
            CS_OUT:  mul_c = r_out_gain;
            default: mul_c = '0;
        endcase
        case (cw.vsel)
            VS_ZA:   mul_v = za_cur;
            VS_ZB:   mul_v = zb_cur;
            VS_Y:    mul_v = r_y;
            VS_Y2:   mul_v = r_y2;
            VS_T:    mul_v = r_t;
            VS_X:    mul_v = r_x;
            default: mul_v = '0;
        endcase
    end

    // sign-magnitude multiply, so rounding is half away from zero
    assign c_abs = mul_c[CW-1] ? (~mul_c + CW'(1)) : mul_c;
    assign v_abs = mul_v[SW-1] ? (~mul_v + SW'(1)) : mul_v;

    assign mag_sum = {1'b0, r_p} + HALF;
    assign mag     = mag_sum[PW:F];

    always_comb begin
        if (|mag[MAGW-1:SW-1]) begin
            n_q = r_p_neg ? ST_MIN : ST_MAX;
        end else if (r_p_neg) begin
            n_q = ~mag[SW-1:0] + SW'(1);
        end else begin
            n_q = mag[SW-1:0];
        end
    end

    assign alu_y  = sat_st(sx(r_x) - sx(r_q));
    assign alu_y2 = sat_st(sx(r_y) - sx(r_q));
    assign alu_t  = sat_st(sx(zb_cur) + sx(r_q) - sx(r_x));
    assign alu_zb = sat_st(sx(za_cur) + sx(r_q));
    assign alu_x  = sat_st(sx(r_x) - sx(r_q));

    assign q_fits = (&r_q[SW-1:SAMPLE_WIDTH-1]) || !(|r_q[SW-1:SAMPLE_WIDTH-1]);
    assign n_sample = q_fits ? r_q[SAMPLE_WIDTH-1:0] : (r_q[SW-1] ? SMP_MIN : SMP_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_band      <= '0;
            r_out_valid <= 1'b0;
            r_out_gain  <= UNITY;
            for (int i = 0; i < NUM_BANDS; i++) begin
                r_coefs[i] <= '0;
                r_za[i]    <= '0;
                r_zb[i]    <= '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BAND1:    r_coefs[0] <= i_cfg_data;
                    CFG_BAND2:    r_coefs[1] <= i_cfg_data;
                    CFG_BAND3:    r_coefs[2] <= i_cfg_data;
                    CFG_OUT_GAIN: r_out_gain <= i_cfg_data[CW-1:0];
                    default:      ;
                endcase
            end

            if (r_busy && cw.alu == ALU_OUT && !hold) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (r_busy && cw.alu == ALU_ZAB) begin
                r_zb[r_band] <= alu_zb;
                r_za[r_band] <= r_y2;
            end

            if (in_xfer) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_band <= '0;
            end else if (r_busy && !hold) begin
                case (cw.seq)
                    SQ_NEXT: r_step <= r_step + STEP_W'(1);
                    SQ_LOOP: begin
                        if (r_band == BAND_W'(NUM_BANDS - 1)) begin
                            r_step <= r_step + STEP_W'(1);
                        end else begin
                            r_band <= r_band + BAND_W'(1);
                            r_step <= cw.target;
                        end
                    end
                    SQ_DONE: r_busy <= 1'b0;
                    default: r_busy <= 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        if (in_xfer) begin
            r_x       <= SW'(i_in_data.sample_in);
            r_blk_end <= i_in_data.block_end_in;
        end
        if (r_busy) begin
            if (cw.mul_en) begin
                r_p     <= PW'(c_abs) * PW'(v_abs);
                r_p_neg <= mul_c[CW-1] ^ mul_v[SW-1];
            end
            case (cw.alu)
                ALU_Y:   r_y  <= alu_y;
                ALU_Y2:  r_y2 <= alu_y2;
                ALU_T:   r_t  <= alu_t;
                ALU_X:   r_x  <= alu_x;
                ALU_OUT: begin
                    if (!hold) begin
                        r_out_data.sample_out    <= n_sample;
                        r_out_data.block_end_out <= r_blk_end;
                    end
                end
                default: ;
            endcase
        end
    end

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step < STEP_W'(UC_LEN)))
        else $error("microprogram step out of range");

    a_band_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_band <= BAND_W'(NUM_BANDS - 1))
        else $error("band counter out of range");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_busy && r_step == '0 && r_band == '0))
        else $error("sample transfer did not start the program at band one");

    a_out_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && hold) |=> (r_busy && $stable(r_step) && r_out_valid))
        else $error("last step did not wait for a full output register");

endmodule

`default_nettype wire
